// File: rtl/ccsr_pkg.sv
// shared widths, constants, register and status codes and types for the css rpm unit
`timescale 1ns / 1ps

package ccsr_pkg;

	// field widths
	localparam int POS_W  = 32;
	localparam int SV_W   = 21;
	localparam int OVR_W  = 12;
	localparam int RPM_W  = 21;
	localparam int RAD_W  = 20;
	localparam int ST_W   = 2;
	localparam int IDX_W  = 3;

	// fixed point
	localparam int FRAC_RAW    = 16;
	localparam int FRAC_W      = 26;
	localparam int DIRECT_FRAC = 10;

	// divider: numerator, divisor in half micrometres, quotient bits
	localparam int K2_W    = 35;
	localparam int NUM_W   = (SV_W - 1) + K2_W;
	localparam int DIV_W   = POS_W + 2;
	localparam int Q_W     = RPM_W + FRAC_W;
	localparam int EXT_W   = DIV_W + Q_W;
	localparam int RAW_W   = Q_W + 1;
	localparam int CLAMP_W = RPM_W + FRAC_RAW;
	localparam int W_W     = RAW_W + OVR_W;
	localparam int PRE_W   = RPM_W + 2;
	localparam int PROD_W  = SV_W + OVR_W + 1;

	// twice the rpm constant in q16
	localparam logic [K2_W-1:0] K2 = 35'd20860756702;

	localparam logic [RPM_W-1:0] OUT_MAX      = 21'd2000000;
	localparam logic [RPM_W-1:0] RPM_RST_MAX  = 21'd2000000;
	localparam logic [RAD_W-1:0] RADIUS_RST   = 20'd1000;

	// register indexes
	localparam logic [IDX_W-1:0] REG_CSS_ENABLE      = 3'd0;
	localparam logic [IDX_W-1:0] REG_DIAMETER_MODE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CLAMP_AFTER_OVR = 3'd2;
	localparam logic [IDX_W-1:0] REG_SPINDLE_MAX     = 3'd3;
	localparam logic [IDX_W-1:0] REG_SPINDLE_MIN     = 3'd4;
	localparam logic [IDX_W-1:0] REG_MACHINE_MAX     = 3'd5;
	localparam logic [IDX_W-1:0] REG_PROGRAM_MAX     = 3'd6;
	localparam logic [IDX_W-1:0] REG_RADIUS_FLOOR    = 3'd7;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_LIMIT   = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD_SET = 2'd2;

	typedef struct packed {
		logic             css_enable;
		logic             diameter_mode;
		logic             clamp_after_override;
		logic [RPM_W-1:0] spindle_max_rpm;
		logic [RPM_W-1:0] spindle_min_rpm;
		logic [RPM_W-1:0] machine_max_rpm;
		logic [RPM_W-1:0] program_max_rpm;
		logic [RAD_W-1:0] radius_floor;
	} cfg_t;

	// per word sideband carried alongside the divider
	typedef struct packed {
		logic                     err;
		logic                     ovf;
		logic [OVR_W-1:0]         ovr;
		logic signed [PROD_W-1:0] prod;
	} side_t;

	typedef struct packed {
		logic [RPM_W-1:0] speed;
		logic [ST_W-1:0]  status;
	} result_t;

endpackage

// File: rtl/ccsr_front.sv
// front end: radius, numerator and direct product, then quotient range check
`timescale 1ns / 1ps

module ccsr_front import ccsr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  cfg_t                     cfg,
	input  logic                     v_i,
	input  logic signed [POS_W-1:0]  position,
	input  logic signed [SV_W-1:0]   set_value,
	input  logic [OVR_W-1:0]         override,
	output logic                     v_o,
	output logic [NUM_W-1:0]         rem_o,
	output logic [DIV_W-1:0]         div_o,
	output side_t                    side_o
);

	logic [POS_W-1:0]         mag;
	logic [RAD_W-1:0]         rmin;
	logic [DIV_W-1:0]         rmin2;
	logic [DIV_W-1:0]         rh;
	logic [DIV_W-1:0]         rhalf;
	logic                     sv_pos;
	logic [NUM_W-1:0]         num;
	logic signed [PROD_W-1:0] prod;
	logic                     ovf;

	logic                     v_s1;
	logic [NUM_W-1:0]         num_s1;
	logic [DIV_W-1:0]         rhalf_s1;
	logic                     err_s1;
	logic [OVR_W-1:0]         ovr_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic                     v_s2;
	logic [NUM_W-1:0]         num_s2;
	logic [DIV_W-1:0]         rhalf_s2;
	side_t                    side_s2;

	always_comb begin
		mag    = position[POS_W-1] ? $unsigned(-position) : $unsigned(position);
		// a zero minimum radius acts as one micrometre
		rmin   = (cfg.radius_floor == '0) ? RAD_W'(1) : cfg.radius_floor;
		rmin2  = DIV_W'({rmin, 1'b0});
		rh     = cfg.diameter_mode ? DIV_W'(mag) : DIV_W'({mag, 1'b0});
		rhalf  = (rh < rmin2) ? rmin2 : rh;
		sv_pos = !set_value[SV_W-1] && (set_value != '0);
		num    = sv_pos ? (NUM_W'(set_value[SV_W-2:0]) * NUM_W'(K2)) : '0;
		prod   = $signed({{(PROD_W-SV_W){set_value[SV_W-1]}}, set_value})
			* $signed({{(PROD_W-OVR_W){1'b0}}, override});
		// quotient does not fit the divider: it is capped downstream anyway
		ovf    = EXT_W'(num_s1) >= {rhalf_s1, {Q_W{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1       <= num;
			rhalf_s1     <= rhalf;
			err_s1       <= cfg.css_enable && !sv_pos;
			ovr_s1       <= override;
			prod_s1      <= prod;
			num_s2       <= num_s1;
			rhalf_s2     <= rhalf_s1;
			side_s2.err  <= err_s1;
			side_s2.ovf  <= ovf;
			side_s2.ovr  <= ovr_s1;
			side_s2.prod <= prod_s1;
		end
	end

	assign v_o    = v_s2;
	assign rem_o  = num_s2;
	assign div_o  = rhalf_s2;
	assign side_o = side_s2;

endmodule

// File: rtl/ccsr_div_cell.sv
// one restoring divider cell: resolves a single quotient bit per stage
`timescale 1ns / 1ps

module ccsr_div_cell import ccsr_pkg::*; #(
	parameter int BIT = Q_W - 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_i,
	input  logic [NUM_W-1:0] rem_i,
	input  logic [DIV_W-1:0] div_i,
	input  logic [Q_W-1:0]   q_i,
	input  side_t            side_i,
	output logic             v_o,
	output logic [NUM_W-1:0] rem_o,
	output logic [DIV_W-1:0] div_o,
	output logic [Q_W-1:0]   q_o,
	output side_t            side_o
);

	logic [EXT_W-1:0] trial;
	logic             fits;
	logic [NUM_W-1:0] rem_n;
	logic [Q_W-1:0]   q_n;

	logic             v_s1;
	logic [NUM_W-1:0] rem_s1;
	logic [DIV_W-1:0] div_s1;
	logic [Q_W-1:0]   q_s1;
	side_t            side_s1;

	always_comb begin
		trial   = EXT_W'(div_i) << BIT;
		fits    = EXT_W'(rem_i) >= trial;
		rem_n   = fits ? (rem_i - trial[NUM_W-1:0]) : rem_i;
		q_n     = q_i;
		q_n[BIT] = fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= rem_n;
			div_s1  <= div_i;
			q_s1    <= q_n;
			side_s1 <= side_i;
		end
	end

	assign v_o    = v_s1;
	assign rem_o  = rem_s1;
	assign div_o  = div_s1;
	assign q_o    = q_s1;
	assign side_o = side_s1;

endmodule

// File: rtl/ccsr_back.sv
// back end: cap and clamp, override multiply, limit decision and output saturation
`timescale 1ns / 1ps

module ccsr_back import ccsr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  cfg_t           cfg,
	input  logic           v_i,
	input  logic [Q_W-1:0] q_i,
	input  side_t          side_i,
	output logic           v_o,
	output result_t        res_o
);

	logic [RPM_W-1:0]         upper_a;
	logic [RPM_W-1:0]         upper;
	logic [RAW_W-1:0]         raw;
	logic [CLAMP_W-1:0]       up16;
	logic [CLAMP_W-1:0]       lo16;
	logic [CLAMP_W-1:0]       c;
	logic [RAW_W-1:0]         op;
	logic [W_W-1:0]           up26;
	logic [W_W-1:0]           lo26;
	logic signed [PROD_W-1:0] up10;
	logic signed [PROD_W-1:0] lo10;
	logic [PRE_W-1:0]         pre;
	logic [ST_W-1:0]          st;

	logic                     v_b1;
	logic [RAW_W-1:0]         op_b1;
	side_t                    side_b1;
	logic                     v_b2;
	logic [W_W-1:0]           w_b2;
	side_t                    side_b2;

	always_comb begin
		upper_a = (cfg.machine_max_rpm < cfg.program_max_rpm) ?
			cfg.machine_max_rpm : cfg.program_max_rpm;
		upper   = (upper_a < cfg.spindle_max_rpm) ? upper_a : cfg.spindle_max_rpm;

		// raw speed is q16, capped at two to the quotient width
		raw  = side_i.ovf ? {1'b1, {Q_W{1'b0}}} : {1'b0, q_i};
		up16 = {upper, {FRAC_RAW{1'b0}}};
		lo16 = {cfg.spindle_min_rpm, {FRAC_RAW{1'b0}}};
		c    = (raw < RAW_W'(up16)) ? raw[CLAMP_W-1:0] : up16;
		if (c < lo16) begin
			c = lo16;
		end
		op   = cfg.clamp_after_override ? raw : RAW_W'(c);
	end

	always_comb begin
		up26 = W_W'({upper, {FRAC_W{1'b0}}});
		lo26 = W_W'({cfg.spindle_min_rpm, {FRAC_W{1'b0}}});
		up10 = $signed(PROD_W'({cfg.spindle_max_rpm, {DIRECT_FRAC{1'b0}}}));
		lo10 = $signed(PROD_W'({cfg.spindle_min_rpm, {DIRECT_FRAC{1'b0}}}));
		pre  = '0;
		st   = ST_OK;
		if (!cfg.css_enable) begin
			// direct speed: a negative product lands on the minimum
			if (side_b2.prod > up10) begin
				pre = PRE_W'(cfg.spindle_max_rpm);
				st  = ST_LIMIT;
			end else if (side_b2.prod < lo10) begin
				pre = PRE_W'(cfg.spindle_min_rpm);
			end else begin
				pre = PRE_W'(side_b2.prod[RPM_W+DIRECT_FRAC-1:DIRECT_FRAC]);
			end
		end else if (side_b2.err) begin
			st = ST_BAD_SET;
		end else if (!cfg.clamp_after_override) begin
			pre = w_b2[FRAC_W+PRE_W-1:FRAC_W];
		end else begin
			if (w_b2 > up26) begin
				pre = PRE_W'(upper);
				st  = ST_LIMIT;
			end else if (w_b2 < lo26) begin
				pre = PRE_W'(cfg.spindle_min_rpm);
			end else begin
				pre = PRE_W'(w_b2[FRAC_W+RPM_W-1:FRAC_W]);
			end
		end
		if (pre > PRE_W'(OUT_MAX)) begin
			pre = PRE_W'(OUT_MAX);
			st  = ST_LIMIT;
		end
		res_o.speed  = pre[RPM_W-1:0];
		res_o.status = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
		end else if (en) begin
			v_b1 <= v_i;
			v_b2 <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_b1   <= op;
			side_b1 <= side_i;
			w_b2    <= W_W'(op_b1) * W_W'(side_b1.ovr);
			side_b2 <= side_b1;
		end
	end

	assign v_o = v_b2;

endmodule

// File: rtl/constant_surface_speed_rpm_unit.sv
// top level of the constant surface speed spindle rpm unit
// Usage:
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one register
//   per word; cfg_ready is always high. Write registers only while the unit is idle.
//   input channel (in_valid/in_ready) takes position, set_value and override;
//   output channel (out_valid/out_ready) returns speed and status, one word per input.
// Pipeline: an accepted word passes two front stages, 47 divider cells, two back
//   stages and the output register before it is shown on the output.
// Throughput: one word per cycle unless stalled; the divider is a chain of cells,
//   one quotient bit per cell, so each word enters the chain as the previous one moves on.
// Stall: when out_ready is low the output register holds its word and a skid
//   register catches the next result; while the skid is full the whole pipeline
//   freezes and in_ready is low. It drops in_ready no earlier than the cycle after
//   the receiver stalls, and rises again when the skid drains.
// Reset: arst_n clears all pipeline valid flags and the output and skid flags,
//   and returns the registers to direct speed mode with limits at 2000000,
//   minimum speed 0 and minimum radius 1000 micrometres.
`timescale 1ns / 1ps

module constant_surface_speed_rpm_unit import ccsr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [RPM_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] position,
	input  logic signed [SV_W-1:0]  set_value,
	input  logic [OVR_W-1:0]        override,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [RPM_W-1:0]        speed,
	output logic [ST_W-1:0]         status
);

	cfg_t             cfg_q;
	logic             en;
	logic             out_v_q;
	logic             skid_v_q;
	result_t          out_q;
	result_t          skid_q;
	logic             pipe_v;
	result_t          res;

	logic             v_c    [0:Q_W];
	logic [NUM_W-1:0] rem_c  [0:Q_W];
	logic [DIV_W-1:0] div_c  [0:Q_W];
	logic [Q_W-1:0]   q_c    [0:Q_W];
	side_t            side_c [0:Q_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.css_enable           <= 1'b0;
			cfg_q.diameter_mode        <= 1'b0;
			cfg_q.clamp_after_override <= 1'b0;
			cfg_q.spindle_max_rpm      <= RPM_RST_MAX;
			cfg_q.spindle_min_rpm      <= '0;
			cfg_q.machine_max_rpm      <= RPM_RST_MAX;
			cfg_q.program_max_rpm      <= RPM_RST_MAX;
			cfg_q.radius_floor         <= RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CSS_ENABLE:      cfg_q.css_enable           <= cfg_data[0];
				REG_DIAMETER_MODE:   cfg_q.diameter_mode        <= cfg_data[0];
				REG_CLAMP_AFTER_OVR: cfg_q.clamp_after_override <= cfg_data[0];
				REG_SPINDLE_MAX:     cfg_q.spindle_max_rpm      <= cfg_data;
				REG_SPINDLE_MIN:     cfg_q.spindle_min_rpm      <= cfg_data;
				REG_MACHINE_MAX:     cfg_q.machine_max_rpm      <= cfg_data;
				REG_PROGRAM_MAX:     cfg_q.program_max_rpm      <= cfg_data;
				REG_RADIUS_FLOOR:    cfg_q.radius_floor         <= cfg_data[RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// the pipeline moves as long as the skid register is free
	assign en       = !skid_v_q;
	assign in_ready = en;

	ccsr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.v_i       (in_valid && in_ready),
		.position  (position),
		.set_value (set_value),
		.override  (override),
		.v_o       (v_c[0]),
		.rem_o     (rem_c[0]),
		.div_o     (div_c[0]),
		.side_o    (side_c[0])
	);

	assign q_c[0] = '0;

	for (genvar j = 0; j < Q_W; j++) begin : g_cell
		ccsr_div_cell #(
			.BIT (Q_W - 1 - j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (v_c[j]),
			.rem_i  (rem_c[j]),
			.div_i  (div_c[j]),
			.q_i    (q_c[j]),
			.side_i (side_c[j]),
			.v_o    (v_c[j+1]),
			.rem_o  (rem_c[j+1]),
			.div_o  (div_c[j+1]),
			.q_o    (q_c[j+1]),
			.side_o (side_c[j+1])
		);
	end

	// final remainder and divisor are not needed past the last cell
	ccsr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg_q),
		.v_i    (v_c[Q_W]),
		.q_i    (q_c[Q_W]),
		.side_i (side_c[Q_W]),
		.v_o    (pipe_v),
		.res_o  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (pipe_v) begin
			if (out_v_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (pipe_v) begin
			if (out_v_q && !out_ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_v_q;
	assign speed     = out_q.speed;
	assign status    = out_q.status;

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held without an output word");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && out_ready |=> out_v_q && !skid_v_q)
		else $error("skid word not moved to output");

	a_bad_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_q.status == ST_BAD_SET) |-> (out_q.speed == '0))
		else $error("bad set value with nonzero speed");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.speed <= OUT_MAX) && (out_q.status <= ST_BAD_SET))
		else $error("speed or status out of range");

endmodule

// File: dv/ccsr_speed_checker.sv
// checker for the css rpm unit: tracks register writes, predicts each speed word and compares
`timescale 1ns / 1ps

module ccsr_speed_checker import ccsr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [RPM_W-1:0]        cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic signed [POS_W-1:0] position,
	input  logic signed [SV_W-1:0]  set_value,
	input  logic [OVR_W-1:0]        override,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [RPM_W-1:0]        speed,
	input  logic [ST_W-1:0]         status,
	output int                      mismatch_count,
	output int                      words_pending,
	output int                      words_checked
);

	// 159154.9431 in q16; doubled in use because the radius is held in half micrometres
	localparam longint unsigned RPM_K_Q16 = 64'd10430378351;
	localparam longint unsigned RAW_LIMIT = 64'd1 << 48;
	localparam longint unsigned SPEED_TOP = 64'd2000000;

	localparam cfg_t REGS_AT_RESET = '{
		css_enable: 1'b0,
		diameter_mode: 1'b0,
		clamp_after_override: 1'b0,
		spindle_max_rpm: 21'd2000000,
		spindle_min_rpm: 21'd0,
		machine_max_rpm: 21'd2000000,
		program_max_rpm: 21'd2000000,
		radius_floor: 20'd1000
	};

	cfg_t    regs;
	result_t expected_speeds[$];

	function automatic result_t predict_speed(input cfg_t c, input logic signed [POS_W-1:0] p,
			input logic signed [SV_W-1:0] sv, input logic [OVR_W-1:0] ovr);
		longint signed   s;
		longint signed   pl;
		longint signed   ovr_l;
		longint signed   prod;
		longint signed   lim_hi;
		longint signed   lim_lo;
		longint unsigned mag;
		longint unsigned rmin;
		longint unsigned rhalf;
		longint unsigned raw;
		longint unsigned upper;
		longint unsigned floor_rpm;
		longint unsigned clamped;
		longint unsigned wide;
		longint unsigned spd;
		logic [ST_W-1:0] st;
		s = sv;
		ovr_l = ovr;
		st = ST_OK;
		floor_rpm = c.spindle_min_rpm;
		if (!c.css_enable) begin
			prod = s * ovr_l;
			lim_hi = c.spindle_max_rpm;
			lim_hi = lim_hi * 1024;
			lim_lo = c.spindle_min_rpm;
			lim_lo = lim_lo * 1024;
			if (prod > lim_hi) begin
				spd = c.spindle_max_rpm;
				st = ST_LIMIT;
			end else if (prod < lim_lo) begin
				spd = floor_rpm;
			end else begin
				spd = prod / 1024;
			end
		end else if (s <= 0) begin
			return '{speed: '0, status: ST_BAD_SET};
		end else begin
			pl = p;
			mag = (pl < 0) ? -pl : pl;
			rmin = c.radius_floor;
			if (rmin == 0)
				rmin = 1;
			rhalf = c.diameter_mode ? mag : mag * 2;
			if (rhalf < rmin * 2)
				rhalf = rmin * 2;
			raw = (longint'(s) * RPM_K_Q16 * 2) / rhalf;
			if (raw > RAW_LIMIT)
				raw = RAW_LIMIT;
			upper = c.machine_max_rpm;
			if (c.program_max_rpm < upper)
				upper = c.program_max_rpm;
			if (c.spindle_max_rpm < upper)
				upper = c.spindle_max_rpm;
			if (!c.clamp_after_override) begin
				clamped = (raw < (upper << 16)) ? raw : (upper << 16);
				if (clamped < (floor_rpm << 16))
					clamped = floor_rpm << 16;
				spd = (clamped * ovr_l) >> 26;
			end else begin
				wide = raw * ovr_l;
				if (wide > (upper << 26)) begin
					spd = upper;
					st = ST_LIMIT;
				end else if (wide < (floor_rpm << 26)) begin
					spd = floor_rpm;
				end else begin
					spd = wide >> 26;
				end
			end
		end
		if (spd > SPEED_TOP) begin
			spd = SPEED_TOP;
			st = ST_LIMIT;
		end
		return '{speed: spd[RPM_W-1:0], status: st};
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		int errs;
		if (!arst_n) begin
			regs <= REGS_AT_RESET;
			expected_speeds.delete();
			mismatch_count <= 0;
			words_pending <= 0;
			words_checked <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CSS_ENABLE:      regs.css_enable <= cfg_data[0];
					REG_DIAMETER_MODE:   regs.diameter_mode <= cfg_data[0];
					REG_CLAMP_AFTER_OVR: regs.clamp_after_override <= cfg_data[0];
					REG_SPINDLE_MAX:     regs.spindle_max_rpm <= cfg_data;
					REG_SPINDLE_MIN:     regs.spindle_min_rpm <= cfg_data;
					REG_MACHINE_MAX:     regs.machine_max_rpm <= cfg_data;
					REG_PROGRAM_MAX:     regs.program_max_rpm <= cfg_data;
					REG_RADIUS_FLOOR:    regs.radius_floor <= cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
			// output first: a word leaving at the same edge belongs to an older input
			if (out_valid && out_ready) begin
				if (expected_speeds.size() == 0) begin
					$error("unexpected word: speed %0d status %0d", speed, status);
					errs++;
				end else begin
					want = expected_speeds.pop_front();
					if (speed !== want.speed) begin
						$error("speed: expected %0d, got %0d", want.speed, speed);
						errs++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errs++;
					end
					words_checked <= words_checked + 1;
				end
			end
			if (in_valid && in_ready)
				expected_speeds.push_back(predict_speed(regs, position, set_value, override));
			mismatch_count <= mismatch_count + errs;
			words_pending <= expected_speeds.size();
		end
	end

endmodule

// File: dv/tb_constant_surface_speed_rpm_unit.sv
// testbench top for the css rpm unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_constant_surface_speed_rpm_unit import ccsr_pkg::*;;

	localparam int RAND_PHASES     = 10;
	localparam int WORDS_PER_PHASE = 110;
	localparam int HOLD_CYCLES     = 200;
	localparam int TAIL_CYCLES     = 60;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [IDX_W-1:0]        cfg_index;
	logic [RPM_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [POS_W-1:0] position;
	logic signed [SV_W-1:0]  set_value;
	logic [OVR_W-1:0]        override;
	logic                    out_valid;
	logic                    out_ready;
	logic [RPM_W-1:0]        speed;
	logic [ST_W-1:0]         status;

	int   mismatch_count;
	int   words_pending;
	int   words_checked;
	int   words_sent;
	int   settings_written;
	int   hold_asks;
	logic stall_on;

	constant_surface_speed_rpm_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.position(position), .set_value(set_value), .override(override),
		.out_valid(out_valid), .out_ready(out_ready), .speed(speed), .status(status)
	);

	ccsr_speed_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.position(position), .set_value(set_value), .override(override),
		.out_valid(out_valid), .out_ready(out_ready), .speed(speed), .status(status),
		.mismatch_count(mismatch_count), .words_pending(words_pending),
		.words_checked(words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("tb_constant_surface_speed_rpm_unit: done, errors");
		$finish;
	end

	// valid stays high after acceptance; the next call either lowers it for a gap or reuses it
	task automatic send_word(input logic signed [POS_W-1:0] p, input logic signed [SV_W-1:0] sv,
			input logic [OVR_W-1:0] ovr);
		if (stall_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		position <= p;
		set_value <= sv;
		override <= ovr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RPM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input cfg_t c);
		write_reg(REG_CSS_ENABLE, RPM_W'(c.css_enable));
		write_reg(REG_DIAMETER_MODE, RPM_W'(c.diameter_mode));
		write_reg(REG_CLAMP_AFTER_OVR, RPM_W'(c.clamp_after_override));
		write_reg(REG_SPINDLE_MAX, c.spindle_max_rpm);
		write_reg(REG_SPINDLE_MIN, c.spindle_min_rpm);
		write_reg(REG_MACHINE_MAX, c.machine_max_rpm);
		write_reg(REG_PROGRAM_MAX, c.program_max_rpm);
		write_reg(REG_RADIUS_FLOOR, RPM_W'(c.radius_floor));
		settings_written++;
	endtask

	function automatic logic [RPM_W-1:0] rand_ceiling();
		case ($urandom_range(0, 7))
			0:       return '0;
			1, 2:    return 21'd2000000;
			default: return RPM_W'($urandom_range(0, 2000000) >> $urandom_range(0, 16));
		endcase
	endfunction

	// receiver: short random stalls, plus one long hold-off on request
	initial begin : receiver
		int served;
		served = 0;
		out_ready <= 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_asks != served) begin
				served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		cfg_t                    plan;
		logic [POS_W-1:0]        mag;
		logic signed [POS_W-1:0] p;
		logic signed [SV_W-1:0]  sv;
		logic [OVR_W-1:0]        ovr;
		in_valid <= 1'b0;
		position <= '0;
		set_value <= '0;
		override <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		stall_on <= 1'b1;
		hold_asks <= 0;
		words_sent = 0;
		settings_written = 0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers as reset: direct speed, full limits
		send_word(0, 21'sd1000000, 12'd4095);
		send_word(0, -21'sd1000000, 12'd1024);
		send_word(0, 21'sd0, 12'd0);
		send_word(123, 21'sd12345, 12'd1024);
		send_word(-1, -21'sd1048576, 12'd4095);
		send_word(7, 21'sd1048575, 12'd1);
		send_word(0, 21'sd1000000, 12'd1024);

		// css by radius, clamp then override, zero min radius
		drain_results();
		plan = '{css_enable: 1'b1, diameter_mode: 1'b0, clamp_after_override: 1'b0,
			spindle_max_rpm: 21'd2000000, spindle_min_rpm: 21'd0, machine_max_rpm: 21'd2000000,
			program_max_rpm: 21'd2000000, radius_floor: 20'd0};
		write_all(plan);
		send_word(0, 21'sd1000000, 12'd4095);
		send_word(32'sh80000000, 21'sd1, 12'd1024);
		send_word(32'sh7fffffff, 21'sd1000000, 12'd4095);
		send_word(5000, 21'sd0, 12'd1024);
		send_word(5000, -21'sd1, 12'd1024);
		send_word(-5000, -21'sd1048576, 12'd0);
		send_word(25000, 21'sd2000, 12'd0);
		send_word(25000, 21'sd2000, 12'd1024);

		// css by diameter, override then clamp, minimum above the ceiling
		drain_results();
		plan = '{css_enable: 1'b1, diameter_mode: 1'b1, clamp_after_override: 1'b1,
			spindle_max_rpm: 21'd2000000, spindle_min_rpm: 21'd1500000, machine_max_rpm: 21'd2000000,
			program_max_rpm: 21'd1000000, radius_floor: 20'd1000000};
		write_all(plan);
		send_word(0, 21'sd1000000, 12'd4095);
		send_word(32'sh7fffffff, 21'sd1, 12'd1);
		send_word(-3000000, 21'sd5000, 12'd1024);
		send_word(1000000, 21'sd1000000, 12'd4095);

		// direct speed with the minimum above the maximum
		drain_results();
		plan = '{css_enable: 1'b0, diameter_mode: 1'b0, clamp_after_override: 1'b0,
			spindle_max_rpm: 21'd1000000, spindle_min_rpm: 21'd1500000, machine_max_rpm: 21'd0,
			program_max_rpm: 21'd0, radius_floor: 20'd1};
		write_all(plan);
		send_word(0, 21'sd1000000, 12'd1024);
		send_word(0, 21'sd1000000, 12'd1025);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			// sender pauses here until every word of the last setting is back
			drain_results();
			plan.css_enable = (ph == 0) ? 1'b0 : (ph < 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
			plan.diameter_mode = (ph == 2) ? 1'b1 : 1'($urandom_range(0, 1));
			plan.clamp_after_override = (ph == 2) ? 1'b1 : (ph == 1) ? 1'b0 :
				1'($urandom_range(0, 1));
			plan.spindle_max_rpm = rand_ceiling();
			plan.machine_max_rpm = rand_ceiling();
			plan.program_max_rpm = rand_ceiling();
			case ($urandom_range(0, 7))
				0, 1:    plan.spindle_min_rpm = '0;
				2:       plan.spindle_min_rpm = 21'd2000000;
				default: plan.spindle_min_rpm =
					RPM_W'($urandom_range(0, 200000) >> $urandom_range(0, 16));
			endcase
			case ($urandom_range(0, 5))
				0:       plan.radius_floor = '0;
				1:       plan.radius_floor = 20'd1;
				2:       plan.radius_floor = 20'd1000000;
				default: plan.radius_floor =
					RAD_W'($urandom_range(1, 1000000) >> $urandom_range(0, 15));
			endcase
			write_all(plan);
			stall_on <= (ph != 3) && (ph < RAND_PHASES - 2);
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if (ph == 5 && k == 20)
					hold_asks <= hold_asks + 1;
				case ($urandom_range(0, 7))
					0: begin
						case ($urandom_range(0, 3))
							0:       p = 32'sh80000000;
							1:       p = 32'sh7fffffff;
							2:       p = 0;
							default: p = -1;
						endcase
					end
					1: p = $urandom();
					default: begin
						// spread the radius over many decades
						mag = $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 31);
						p = $urandom_range(0, 1) ? -mag : mag;
					end
				endcase
				case ($urandom_range(0, 9))
					0: sv = -SV_W'($urandom_range(0, 1000000) >> $urandom_range(0, 19));
					1: begin
						case ($urandom_range(0, 3))
							0:       sv = 21'sd1;
							1:       sv = 21'sd1000000;
							2:       sv = -21'sd1000000;
							default: sv = 21'sd0;
						endcase
					end
					default: sv = SV_W'($urandom_range(1, 1000000) >> $urandom_range(0, 19));
				endcase
				case ($urandom_range(0, 5))
					0:       ovr = 12'd1024;
					1:       ovr = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
					default: ovr = OVR_W'($urandom_range(0, 4095));
				endcase
				send_word(p, sv, ovr);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d words over %0d register settings, %0d results checked",
			words_sent, settings_written, words_checked);
		$display("direct and css modes, radius and diameter, both clamp orders, long output hold");
		if (mismatch_count == 0 && words_pending == 0)
			$display("tb_constant_surface_speed_rpm_unit: done, clean");
		else
			$display("tb_constant_surface_speed_rpm_unit: done, errors");
		$finish;
	end

endmodule
